FILE: hw/rtl/abc_pkg.sv
// Shared constants, codes and arithmetic helpers for the clipped alpha blitter.
package abc_pkg;

  // Destination frame size in pixels
  localparam int DEST_WIDTH  = 256;
  localparam int DEST_HEIGHT = 256;

  localparam int ADDR_W = 16;
  localparam int PIX_W  = 32;
  localparam int CFG_W  = 13;
  localparam int CLIP_W = 16;

  // Transaction kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_BLIT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEST_X     = 3'd2;
  localparam logic [2:0] REG_DEST_Y     = 3'd3;
  localparam logic [2:0] REG_SRC_X      = 3'd4;
  localparam logic [2:0] REG_SRC_Y      = 3'd5;
  localparam logic [2:0] REG_RECT_W     = 3'd6;
  localparam logic [2:0] REG_RECT_H     = 3'd7;

  // One clipped axis: destination start, source start, length
  typedef struct packed {
    logic signed [CLIP_W-1:0] d;
    logic signed [CLIP_W-1:0] s;
    logic signed [CLIP_W-1:0] len;
  } axis_t;

  // floor(m / 255) for m below 65280, by reciprocal with correction
  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [16:0] t;
    t = {1'b0, m} + 17'd1;
    t = t + (t >> 8);
    return t[15:8];
  endfunction

endpackage

FILE: hw/rtl/alpha_blit_clipped.sv
// Top level of the clipped alpha blitter with its frame buffer memory.
// Usage:
//   Input transactions are taken when start is high and busy is low.
//   kind load writes pixel to frame word address; kind read returns the word
//   at address on read_pixel, marked by strobe in the cycle after acceptance.
//   kind blit carries one source pixel at src_col/src_row; it is clipped
//   against the source rectangle, the source image and the destination frame,
//   then copied or alpha blended into the frame buffer.
//   Load and read never raise busy.
//   A blit holds busy after acceptance through the states CLIP1 and CLIP2
//   for clipping, TEST for the window test and address, then READ, MUL and
//   WRITE for a read, multiply and write-back through the frame memory.
//   Blits outside the clipped rectangle end after the test cycle.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once;
//   write only while no transaction is in flight.
//   Reset: rst clears the registers and sequencer; frame memory is not
//   cleared and each word must be loaded before it is read or blended.
//   The receiver cannot stall: read_pixel is valid for the strobe cycle only.
module alpha_blit_clipped (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] address,
  input  logic [31:0] pixel,
  input  logic [11:0] src_col,
  input  logic [11:0] src_row,
  input  logic        blend,
  output logic [31:0] read_pixel,
  output logic        strobe,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLIP1 = 3'd1;
  localparam logic [2:0] ST_CLIP2 = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  localparam int CW = abc_pkg::CLIP_W;

  logic [2:0]  state;
  logic [2:0]  state_next;

  logic [12:0] src_width, src_height, dest_x, dest_y, src_x, src_y, rect_w, rect_h;

  logic [31:0] frame [1 << abc_pkg::ADDR_W];
  logic [31:0] mem_rdata;
  logic [15:0] mem_raddr;
  logic        mem_we;
  logic [15:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic [11:0] blit_col, blit_row;
  logic [31:0] blit_pix;
  logic        blit_blend;
  logic [15:0] blit_idx;

  abc_pkg::axis_t ax1, ay1, ax2, ay2;
  abc_pkg::axis_t ax1_next, ay1_next, ax2_next, ay2_next;

  logic        accept;
  logic        in_window;
  logic [15:0] idx_next;
  logic [31:0] mix_result;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= '0;
      src_height <= '0;
      dest_x     <= '0;
      dest_y     <= '0;
      src_x      <= '0;
      src_y      <= '0;
      rect_w     <= '0;
      rect_h     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        abc_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        abc_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        abc_pkg::REG_DEST_X:     dest_x     <= cfg_data;
        abc_pkg::REG_DEST_Y:     dest_y     <= cfg_data;
        abc_pkg::REG_SRC_X:      src_x      <= cfg_data;
        abc_pkg::REG_SRC_Y:      src_y      <= cfg_data;
        abc_pkg::REG_RECT_W:     rect_w     <= cfg_data;
        abc_pkg::REG_RECT_H:     rect_h     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clip, first half: pull negative source and destination starts to zero
  function automatic abc_pkg::axis_t clip_head(input logic [12:0] d, input logic [12:0] s,
                                               input logic [12:0] len);
    abc_pkg::axis_t a;
    a.d   = CW'($signed(d));
    a.s   = CW'($signed(s));
    a.len = CW'({1'b0, len});
    if (a.s < 0) begin
      a.d   = a.d - a.s;
      a.len = a.len + a.s;
      a.s   = '0;
    end
    if (a.d < 0) begin
      a.s   = a.s - a.d;
      a.len = a.len + a.d;
      a.d   = '0;
    end
    return a;
  endfunction

  // Clip, second half: trim length to destination and source extents
  function automatic abc_pkg::axis_t clip_tail(input abc_pkg::axis_t a_in,
                                               input logic [12:0] src_dim,
                                               input logic signed [CW-1:0] dst_dim);
    abc_pkg::axis_t a;
    logic signed [CW-1:0] sdim;
    a    = a_in;
    sdim = CW'({1'b0, src_dim});
    if (a.len + a.d > dst_dim) a.len = dst_dim - a.d;
    if (a.len + a.s > sdim) a.len = sdim - a.s;
    return a;
  endfunction

  assign ax1_next = clip_head(dest_x, src_x, rect_w);
  assign ay1_next = clip_head(dest_y, src_y, rect_h);
  assign ax2_next = clip_tail(ax1, src_width, CW'(abc_pkg::DEST_WIDTH));
  assign ay2_next = clip_tail(ay1, src_height, CW'(abc_pkg::DEST_HEIGHT));

  // Window test and destination word index
  always_comb begin
    logic signed [CW-1:0] c, r;
    logic [15:0] drow, dcol;
    c = CW'({1'b0, blit_col});
    r = CW'({1'b0, blit_row});
    in_window = (ax2.len >= 1) && (ay2.len >= 1)
             && (c >= ax2.s) && (c < ax2.s + ax2.len)
             && (r >= ay2.s) && (r < ay2.s + ay2.len);
    drow = 16'(ay2.d + r - ay2.s);
    dcol = 16'(ax2.d + c - ax2.s);
    idx_next = 16'(drow * 16'(abc_pkg::DEST_WIDTH)) + dcol;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && kind == abc_pkg::KIND_BLIT) state_next = ST_CLIP1;
      ST_CLIP1: state_next = ST_CLIP2;
      ST_CLIP2: state_next = ST_TEST;
      ST_TEST:  state_next = in_window ? ST_READ : ST_IDLE;
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= accept && kind == abc_pkg::KIND_READ;
    end
  end

  // Blit payload and clip pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      blit_col   <= src_col;
      blit_row   <= src_row;
      blit_pix   <= pixel;
      blit_blend <= blend;
    end
    if (state == ST_CLIP1) begin
      ax1 <= ax1_next;
      ay1 <= ay1_next;
    end
    if (state == ST_CLIP2) begin
      ax2 <= ax2_next;
      ay2 <= ay2_next;
    end
    if (state == ST_TEST) blit_idx <= idx_next;
  end

  abc_mix u_mix (
    .clk    (clk),
    .dst    (mem_rdata),
    .src    (blit_pix),
    .blend  (blit_blend),
    .result (mix_result)
  );

  // Frame memory port selection: loads while idle, write-back at end of blit
  always_comb begin
    mem_raddr = (state == ST_IDLE) ? address : blit_idx;
    mem_we    = 1'b0;
    mem_waddr = address;
    mem_wdata = pixel;
    if (state == ST_IDLE && accept && kind == abc_pkg::KIND_LOAD) begin
      mem_we = 1'b1;
    end else if (state == ST_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = blit_idx;
      mem_wdata = mix_result;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame[mem_waddr] <= mem_wdata;
    mem_rdata <= frame[mem_raddr];
  end

  assign read_pixel = mem_rdata;

endmodule

FILE: hw/rtl/abc_mix.sv
// Two-stage alpha blend of one source word over one destination word.
module abc_mix (
  input  logic        clk,
  input  logic [31:0] dst,
  input  logic [31:0] src,
  input  logic        blend,
  output logic [31:0] result
);

  logic signed [17:0] prod [3];
  logic [31:0]        dst_q;
  logic [31:0]        src_q;
  logic               blend_q;

  // Stage one: signed difference times source alpha per colour channel
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] <= 18'($signed({1'b0, src[ch*8 +: 8]}) - $signed({1'b0, dst[ch*8 +: 8]}))
                  * $signed({10'd0, src[31:24]});
    end
    dst_q   <= dst;
    src_q   <= src;
    blend_q <= blend;
  end

  // Stage two: divide by 255 toward zero and add back to the destination
  always_comb begin
    logic [17:0] mag;
    logic [7:0]  q;
    logic [23:0] col;
    col = '0;
    for (int ch = 0; ch < 3; ch++) begin
      mag = prod[ch][17] ? 18'(-prod[ch]) : 18'(prod[ch]);
      q   = abc_pkg::div255(mag[15:0]);
      col[ch*8 +: 8] = prod[ch][17] ? dst_q[ch*8 +: 8] - q : dst_q[ch*8 +: 8] + q;
    end
    result = blend_q ? {src_q[31:24], col} : src_q;
  end

endmodule
